FILE: rtl/mpcl_pkg.sv
package mpcl_pkg;

    localparam int LINE_LIMIT = 49;
    localparam int LEN_W      = $clog2(LINE_LIMIT);
    localparam int DUTY_W     = 7;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 7'd100;

    // |v|*255 with |v| <= 128 fits in 15 bits
    localparam int DIVD_W    = 15;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] FULL_CMP = 8'hff;

    typedef enum logic [2:0] {
        PH_WS1,
        PH_SIGN1,
        PH_DIG1,
        PH_WS2,
        PH_SIGN2,
        PH_DIG2,
        PH_DONE,
        PH_FAIL
    } t_phase;

    typedef enum logic [1:0] {
        S_RECV,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic line_end;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/motor_pair_command_line_parser.sv
// Motor pair command line parser. Bytes come in on the slave stream, one word
// per cycle while o_s_tready is high, and are scanned on the fly as two signed
// decimal numbers split by a comma ("%d,%d"); a line ends on CR, LF or its 49th
// byte. Each line gives one master word: tuser is the parse flag, tdata holds
// both 8-bit speeds and the H-bridge compare pair of each motor, all zero on a
// parse error. The line-ending byte starts a two-lane restoring divider for
// |v|*255/max_duty, then the output register is loaded, waiting while the
// output word is held by the sink. The input is not ready during the divide
// and load. max_duty resets to 100 and is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while the block is idle, the block does not enforce this.
module motor_pair_command_line_parser
    import mpcl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DUTY_W-1:0] i_cfg_wdata,   // max_duty
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,     // in_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // speed_left, speed_right, left_fwd_compare, left_rev_compare,
    // right_fwd_compare, right_rev_compare
    output logic [47:0]       o_m_tdata,
    output logic              o_m_tuser      // parse_ok
);

    t_cmd  cmd;
    t_stat stat;

    mpcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    mpcl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_s_tdata),
        .i_cmd       (cmd),
        .i_m_tready  (i_m_tready),
        .o_stat      (stat),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

FILE: rtl/mpcl_ctrl.sv
module mpcl_ctrl
    import mpcl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  t_stat i_stat,
    output logic  o_s_tready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RECV: begin
                if (i_s_tvalid && i_stat.line_end) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = S_RECV;
                end
            end
            default: n_state = S_RECV;
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.load   = 1'b0;
        case (r_state)
            S_RECV: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load = i_stat.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/mpcl_dp.sv
module mpcl_dp
    import mpcl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DUTY_W-1:0] i_cfg_wdata,
    input  logic [7:0]        i_byte,
    input  t_cmd              i_cmd,
    input  logic              i_m_tready,
    output t_stat             o_stat,
    output logic              o_m_tvalid,
    output logic [47:0]       o_m_tdata,
    output logic              o_m_tuser
);

    logic [DUTY_W-1:0] r_max_duty;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [LEN_W-1:0]  r_len;
    logic              r_neg1;
    logic              n_neg1;
    logic [7:0]        r_mag1;
    logic [7:0]        n_mag1;
    logic              r_neg2;
    logic              n_neg2;
    logic [7:0]        r_mag2;
    logic [7:0]        n_mag2;

    logic              r_ok;
    logic [7:0]        r_v1;
    logic [7:0]        r_v2;
    logic [DIVD_W-1:0] r_q1;
    logic [DIVD_W-1:0] r_q2;
    logic [DUTY_W-1:0] r_rem1;
    logic [DUTY_W-1:0] r_rem2;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_out_valid;
    logic              r_out_ok;
    logic [47:0]       r_out_data;

    logic              dig;
    logic              spc;
    logic [7:0]        dval;
    logic              ok_now;
    logic [7:0]        v1_now;
    logic [7:0]        v2_now;
    logic [7:0]        abs1;
    logic [7:0]        abs2;
    logic [15:0]       prod1;
    logic [15:0]       prod2;
    logic [DUTY_W:0]   t1;
    logic [DUTY_W:0]   t2;
    logic              ge1;
    logic              ge2;
    logic [DUTY_W:0]   sub1;
    logic [DUTY_W:0]   sub2;
    logic [7:0]        duty1;
    logic [7:0]        duty2;
    logic [7:0]        fwd1;
    logic [7:0]        rev1;
    logic [7:0]        fwd2;
    logic [7:0]        rev2;

    function automatic logic [7:0] acc10(input logic [7:0] mag, input logic [7:0] d);
        acc10 = {mag[4:0], 3'b000} + {mag[6:0], 1'b0} + d;
    endfunction

    function automatic logic [7:0] abs8(input logic [7:0] v);
        abs8 = v[7] ? 8'(-v) : v;
    endfunction

    // scanner
    always_comb begin
        dig    = (i_byte inside {[CH_ZERO:CH_NINE]});
        spc    = (i_byte == CH_SPACE) || (i_byte inside {[CH_TAB:CH_CR]});
        dval   = {4'b0000, i_byte[3:0]};
        n_phase = r_phase;
        n_neg1  = r_neg1;
        n_mag1  = r_mag1;
        n_neg2  = r_neg2;
        n_mag2  = r_mag2;
        if (i_byte == CH_NUL) begin
            n_phase = (r_phase == PH_DIG2 || r_phase == PH_DONE) ? PH_DONE : PH_FAIL;
        end else begin
            case (r_phase)
                PH_WS1: begin
                    if (spc) begin
                        n_phase = PH_WS1;
                    end else if (i_byte == CH_PLUS || i_byte == CH_MINUS) begin
                        n_neg1  = (i_byte == CH_MINUS);
                        n_phase = PH_SIGN1;
                    end else if (dig) begin
                        n_mag1  = dval;
                        n_phase = PH_DIG1;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_SIGN1: begin
                    if (dig) begin
                        n_mag1  = dval;
                        n_phase = PH_DIG1;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_DIG1: begin
                    if (dig) begin
                        n_mag1 = acc10(r_mag1, dval);
                    end else begin
                        n_phase = (i_byte == CH_COMMA) ? PH_WS2 : PH_FAIL;
                    end
                end
                PH_WS2: begin
                    if (spc) begin
                        n_phase = PH_WS2;
                    end else if (i_byte == CH_PLUS || i_byte == CH_MINUS) begin
                        n_neg2  = (i_byte == CH_MINUS);
                        n_phase = PH_SIGN2;
                    end else if (dig) begin
                        n_mag2  = dval;
                        n_phase = PH_DIG2;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_SIGN2: begin
                    if (dig) begin
                        n_mag2  = dval;
                        n_phase = PH_DIG2;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_DIG2: begin
                    if (dig) begin
                        n_mag2 = acc10(r_mag2, dval);
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    assign o_stat.line_end = (i_byte == CH_LF) || (i_byte == CH_CR) ||
                             (r_len == LEN_W'(LINE_LIMIT - 1));

    assign ok_now = (n_phase == PH_DIG2) || (n_phase == PH_DONE);
    assign v1_now = n_neg1 ? 8'(-n_mag1) : n_mag1;
    assign v2_now = n_neg2 ? 8'(-n_mag2) : n_mag2;
    assign abs1   = abs8(v1_now);
    assign abs2   = abs8(v2_now);
    // |v|*255 as a shift and subtract
    assign prod1  = {abs1, 8'h00} - {8'h00, abs1};
    assign prod2  = {abs2, 8'h00} - {8'h00, abs2};

    // restoring divider, one quotient bit per lane per cycle
    assign t1   = {r_rem1, r_q1[DIVD_W-1]};
    assign t2   = {r_rem2, r_q2[DIVD_W-1]};
    assign ge1  = (t1 >= {1'b0, r_max_duty});
    assign ge2  = (t2 >= {1'b0, r_max_duty});
    assign sub1 = t1 - {1'b0, r_max_duty};
    assign sub2 = t2 - {1'b0, r_max_duty};

    assign o_stat.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty <= MAX_DUTY_RST;
        end else if (i_cfg_we) begin
            r_max_duty <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WS1;
            r_len   <= '0;
            r_neg1  <= 1'b0;
            r_mag1  <= '0;
            r_neg2  <= 1'b0;
            r_mag2  <= '0;
        end else if (i_cmd.accept) begin
            if (o_stat.line_end) begin
                r_phase <= PH_WS1;
                r_len   <= '0;
                r_neg1  <= 1'b0;
                r_mag1  <= '0;
                r_neg2  <= 1'b0;
                r_mag2  <= '0;
            end else begin
                r_phase <= n_phase;
                r_len   <= r_len + LEN_W'(1);
                r_neg1  <= n_neg1;
                r_mag1  <= n_mag1;
                r_neg2  <= n_neg2;
                r_mag2  <= n_mag2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.accept && o_stat.line_end) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_stat.line_end) begin
            r_ok   <= ok_now;
            r_v1   <= v1_now;
            r_v2   <= v2_now;
            r_q1   <= prod1[DIVD_W-1:0];
            r_q2   <= prod2[DIVD_W-1:0];
            r_rem1 <= '0;
            r_rem2 <= '0;
        end else if (i_cmd.step) begin
            r_rem1 <= ge1 ? sub1[DUTY_W-1:0] : t1[DUTY_W-1:0];
            r_rem2 <= ge2 ? sub2[DUTY_W-1:0] : t2[DUTY_W-1:0];
            r_q1   <= {r_q1[DIVD_W-2:0], ge1};
            r_q2   <= {r_q2[DIVD_W-2:0], ge2};
        end
    end

    // compare pair of each motor
    always_comb begin
        duty1 = (r_max_duty == '0) ? FULL_CMP : r_q1[7:0];
        duty2 = (r_max_duty == '0) ? FULL_CMP : r_q2[7:0];
        fwd1  = r_v1[7] ? FULL_CMP : FULL_CMP - duty1;
        rev1  = r_v1[7] ? FULL_CMP - duty1 : FULL_CMP;
        fwd2  = r_v2[7] ? FULL_CMP : FULL_CMP - duty2;
        rev2  = r_v2[7] ? FULL_CMP - duty2 : FULL_CMP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_ok   <= r_ok;
            r_out_data <= r_ok ? {rev2, fwd2, rev1, fwd1, r_v2, r_v1} : 48'h0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ok;

endmodule

FILE: rtl/mpcl_checker.sv
module mpcl_checker
    import mpcl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [7:0]        i_s_tdata,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [47:0]       o_m_tdata,
    input logic              o_m_tuser
);

    // stalled output word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    // parse error carries an all-zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 48'h0)
        else $error("error word with nonzero payload");

    // idle side of each bridge sits at full compare, chosen by speed sign
    a_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (o_m_tdata[7]  ? o_m_tdata[23:16] == FULL_CMP : o_m_tdata[31:24] == FULL_CMP) &&
            (o_m_tdata[15] ? o_m_tdata[39:32] == FULL_CMP : o_m_tdata[47:40] == FULL_CMP))
        else $error("compare pair does not match speed sign");

    // an accepted CR or LF line end makes the input not ready as the divider starts
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tdata == CH_LF || i_s_tdata == CH_CR)
            |=> !o_s_tready)
        else $error("input ready during divide");

endmodule

bind motor_pair_command_line_parser mpcl_checker u_mpcl_checker (.*);
